### design/crt_pkg.sv
// Shared types and constants of the conveyor reject tracker.
`default_nettype none
package crt_pkg;

    typedef struct packed {
        logic              operation;
        logic [15:0]       elapsed_ms;
        logic signed [31:0] vision_code;
    } t_in;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] part_position;
        logic        last;
    } t_out;

    typedef enum logic {
        K_TICK   = 1'b0,
        K_APPEND = 1'b1
    } t_kind;

    // Work item handed from the front part to the back part.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] elapsed;
        logic [31:0] delta;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } t_back_state;

    localparam logic [1:0] CMD_RETRACT = 2'd0;
    localparam logic [1:0] CMD_EXTEND  = 2'd1;
    localparam logic [1:0] CMD_DROPPED = 2'd2;

    localparam logic [1:0] REG_LINE_SPEED    = 2'd0;
    localparam logic [1:0] REG_PUSH_DISTANCE = 2'd1;
    localparam logic [1:0] REG_RETRACT_DELAY = 2'd2;

    localparam logic [15:0] LINE_SPEED_RST    = 16'd0;
    localparam logic [31:0] PUSH_DISTANCE_RST = 32'd1500000;
    localparam logic [15:0] RETRACT_DELAY_RST = 16'd500;

    localparam logic signed [31:0] CODE_DEFECT = 32'sd1;

endpackage
`default_nettype wire

### design/crt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module crt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

### design/crt_fifo.sv
// Small register-based FIFO used for the tracker's work and result queues.
`default_nettype none
module crt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule
`default_nettype wire

### design/crt_front.sv
// Front part: accepts input items, drops good verdicts, scales tick time to distance.
`default_nettype none
module crt_front
    import crt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_in         i_in,
    output logic             o_full,
    input  wire logic [15:0] i_line_speed,
    output logic             o_cmd_push,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_full
);
    logic        r_fv, n_fv;
    t_kind       r_kind;
    logic [15:0] r_elapsed;
    logic        accept, keep;

    assign o_full = r_fv && i_cmd_full;
    assign accept = i_push && !o_full;
    // Ticks and defect verdicts go on; any other verdict makes no result.
    assign keep   = !i_in.operation || (i_in.vision_code == CODE_DEFECT);
    assign n_fv   = (accept && keep) || (r_fv && i_cmd_full);

    assign o_cmd_push    = r_fv && !i_cmd_full;
    assign o_cmd.kind    = r_kind;
    assign o_cmd.elapsed = r_elapsed;
    assign o_cmd.delta   = {16'd0, i_line_speed} * {16'd0, r_elapsed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_kind    <= i_in.operation ? K_APPEND : K_TICK;
            r_elapsed <= i_in.elapsed_ms;
        end
    end
endmodule
`default_nettype wire

### design/crt_back.sv
// Back part: owns the part store, walks it on ticks and produces results.
`default_nettype none
module crt_back
    import crt_pkg::*;
#(
    parameter int PART_CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cmd_empty,
    output logic             o_cmd_pop,
    input  wire logic [31:0] i_push_distance,
    input  wire logic [15:0] i_retract_delay,
    output logic             o_out_push,
    output t_out             o_out,
    input  wire logic        i_out_full
);
    localparam int IW = (PART_CAPACITY > 1) ? $clog2(PART_CAPACITY) : 1;
    localparam int CW = $clog2(PART_CAPACITY + 1);

    t_back_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_kept, n_kept;
    logic [IW-1:0] r_idx, n_idx;
    logic [31:0]   r_delta, n_delta;
    logic [15:0]   r_remaining, n_remaining;
    logic          r_pending, n_pending;
    logic          r_hold_v, n_hold_v;
    t_out          r_hold, n_hold;

    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data, rd_data;
    logic [32:0]   sum;
    logic [31:0]   q;
    logic          last_part;

    crt_ram #(
        .WIDTH (32),
        .DEPTH (PART_CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Advance the part last read from the store, saturating at the top of the range.
    assign sum       = {1'b0, rd_data} + {1'b0, r_delta};
    assign q         = sum[32] ? '1 : sum[31:0];
    assign last_part = ((CW'(r_idx) + 1'b1) == r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_kept      = r_kept;
        n_idx       = r_idx;
        n_delta     = r_delta;
        n_remaining = r_remaining;
        n_pending   = r_pending;
        n_hold_v    = r_hold_v;
        n_hold      = r_hold;
        o_cmd_pop   = 1'b0;
        o_out_push  = 1'b0;
        o_out       = r_hold;
        rd_en       = 1'b0;
        rd_addr     = r_idx + 1'b1;
        wr_en       = 1'b0;
        wr_addr     = r_kept[IW-1:0];
        wr_data     = q;

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty && !i_out_full) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == K_APPEND) begin
                        if (r_count >= CW'(PART_CAPACITY)) begin
                            o_out_push = 1'b1;
                            o_out      = '{command: CMD_DROPPED, part_position: '0,
                                           last: 1'b1};
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[IW-1:0];
                            wr_data = '0;
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        // Serve the retract countdown before moving parts.
                        if (r_pending) begin
                            if (i_cmd.elapsed >= r_remaining) begin
                                n_remaining = '0;
                                n_pending   = 1'b0;
                                n_hold_v    = 1'b1;
                                n_hold      = '{command: CMD_RETRACT, part_position: '0,
                                                last: 1'b0};
                            end else begin
                                n_remaining = r_remaining - i_cmd.elapsed;
                            end
                        end
                        n_delta = i_cmd.delta;
                        n_idx   = '0;
                        n_kept  = '0;
                        if (r_count == '0) begin
                            n_state = S_FIN;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                if (!i_out_full) begin
                    if (q >= i_push_distance) begin
                        // Release the held result; the new extend may be the last.
                        o_out_push  = r_hold_v;
                        n_hold_v    = 1'b1;
                        n_hold      = '{command: CMD_EXTEND, part_position: q, last: 1'b0};
                        n_remaining = i_retract_delay;
                        n_pending   = 1'b1;
                    end else begin
                        wr_en  = 1'b1;
                        n_kept = r_kept + 1'b1;
                    end
                    if (last_part) begin
                        n_count = n_kept;
                        n_state = S_FIN;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (!i_out_full) begin
                    o_out_push = r_hold_v;
                    o_out.last = 1'b1;
                    n_hold_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_remaining <= '0;
            r_pending   <= 1'b0;
            r_hold_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remaining <= n_remaining;
            r_pending   <= n_pending;
            r_hold_v    <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kept  <= n_kept;
        r_idx   <= n_idx;
        r_delta <= n_delta;
        r_hold  <= n_hold;
    end
endmodule
`default_nettype wire

### design/conveyor_reject_tracker_unit.sv
// Top level of the conveyor reject tracker: registers, queues and the two parts.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  input    | in        | push / full               | i_in  (t_in)
//  result   | out       | empty / pop               | o_out (t_out)
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A defect verdict is handled by the back in its idle state; a tick walks the tracked
// parts in turn through the part store's single read port.
// The front registers each kept item and keeps accepting while the back works.
// Synchronous active-low reset empties the store and both queues.
// A full result queue stalls the back; a full work queue stalls the front.
`default_nettype none
module conveyor_reject_tracker_unit
    import crt_pkg::*;
#(
    parameter int PART_CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    input  wire t_in         i_in,
    output logic             full,
    output logic             empty,
    input  wire logic        pop,
    output t_out             o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    logic [15:0] r_line_speed;
    logic [31:0] r_push_distance;
    logic [15:0] r_retract_delay;

    logic cmd_push, cmd_full, cmd_pop, cmd_empty;
    t_cmd cmd_in, cmd_out;
    logic out_push, out_full;
    t_out out_in;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_speed    <= LINE_SPEED_RST;
            r_push_distance <= PUSH_DISTANCE_RST;
            r_retract_delay <= RETRACT_DELAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LINE_SPEED:    r_line_speed    <= i_cfg_data[15:0];
                REG_PUSH_DISTANCE: r_push_distance <= i_cfg_data;
                REG_RETRACT_DELAY: r_retract_delay <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    crt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_in         (i_in),
        .o_full       (full),
        .i_line_speed (r_line_speed),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in),
        .i_cmd_full   (cmd_full)
    );

    logic [$bits(t_cmd)-1:0] cmd_vec;

    crt_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_vec)
    );

    assign cmd_out = t_cmd'(cmd_vec);

    crt_back #(
        .PART_CAPACITY (PART_CAPACITY)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_out),
        .i_cmd_empty     (cmd_empty),
        .o_cmd_pop       (cmd_pop),
        .i_push_distance (r_push_distance),
        .i_retract_delay (r_retract_delay),
        .o_out_push      (out_push),
        .o_out           (out_in),
        .i_out_full      (out_full)
    );

    logic [$bits(t_out)-1:0] out_vec;

    crt_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (4)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_vec)
    );

    assign o_out = t_out'(out_vec);

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full result queue");

    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("work item pushed into a full work queue");

    a_cmd_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.command == CMD_RETRACT || o_out.command == CMD_EXTEND ||
                    o_out.command == CMD_DROPPED))
        else $error("result carries an undefined command");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.command != CMD_EXTEND) |-> (o_out.part_position == '0))
        else $error("retract or dropped result with nonzero position");
endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking testbench of the conveyor reject tracker: predicts and checks pusher commands.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crt_pkg::*;

    localparam int          PART_CAP      = 16;
    localparam int          SETTLE_CYCLES = 200;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          LIMIT_CYCLES  = 1_000_000;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;

    // Tracks parts on the belt and computes the pusher commands each transaction causes.
    class reject_predictor;
        logic [15:0] line_speed;
        logic [31:0] push_distance;
        logic [15:0] retract_delay;
        logic [31:0] part_pos [PART_CAP];
        int unsigned part_cnt;
        logic [15:0] retract_left;
        bit          retract_armed;
        t_out        cmds_due [$];
        int          n_errors;
        int          n_checked;
        int          n_extend;
        int          n_retract;
        int          n_drop;

        function new();
            line_speed    = LINE_SPEED_RST;
            push_distance = PUSH_DISTANCE_RST;
            retract_delay = RETRACT_DELAY_RST;
            part_cnt      = 0;
            retract_left  = '0;
            retract_armed = 1'b0;
            n_errors      = 0;
            n_checked     = 0;
            n_extend      = 0;
            n_retract     = 0;
            n_drop        = 0;
        endfunction

        function int pending();
            return cmds_due.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_LINE_SPEED:    line_speed    = val[15:0];
                REG_PUSH_DISTANCE: push_distance = val;
                REG_RETRACT_DELAY: retract_delay = val[15:0];
                default: ;
            endcase
        endfunction

        function void note_item(t_in x);
            t_out        batch [$];
            t_out        r;
            logic [31:0] delta;
            logic [32:0] sum;
            logic [31:0] q;
            int unsigned kept;
            int unsigned i;
            if (x.operation == K_APPEND) begin
                if (x.vision_code != CODE_DEFECT) return;
                if (part_cnt >= PART_CAP) begin
                    r = '{command: CMD_DROPPED, part_position: 32'd0, last: 1'b1};
                    cmds_due = {cmds_due, r};
                end else begin
                    part_pos[part_cnt] = '0;
                    part_cnt++;
                end
                return;
            end
            // serve the countdown left by earlier ticks before moving parts
            if (retract_armed) begin
                if (x.elapsed_ms >= retract_left) begin
                    retract_left  = '0;
                    retract_armed = 1'b0;
                    r = '{command: CMD_RETRACT, part_position: 32'd0, last: 1'b0};
                    batch = {batch, r};
                end else begin
                    retract_left -= x.elapsed_ms;
                end
            end
            delta = 32'(line_speed) * 32'(x.elapsed_ms);
            kept  = 0;
            for (i = 0; i < part_cnt; i++) begin
                sum = {1'b0, part_pos[i]} + {1'b0, delta};
                q   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                if (q >= push_distance) begin
                    r = '{command: CMD_EXTEND, part_position: q, last: 1'b0};
                    batch = {batch, r};
                    retract_left  = retract_delay;
                    retract_armed = 1'b1;
                end else begin
                    part_pos[kept] = q;
                    kept++;
                end
            end
            part_cnt = kept;
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            cmds_due = {cmds_due, batch};
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (cmds_due.size() == 0) begin
                $error("unexpected result: command %0d, part_position %0d, last %0d",
                       got.command, got.part_position, got.last);
                n_errors++;
                return;
            end
            want = cmds_due.pop_front();
            n_checked++;
            if (got.command !== want.command) begin
                $error("command: expected %0d, got %0d", want.command, got.command);
                n_errors++;
            end
            if (got.part_position !== want.part_position) begin
                $error("part_position: expected %0d, got %0d",
                       want.part_position, got.part_position);
                n_errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                n_errors++;
            end
            case (want.command)
                CMD_EXTEND:  n_extend++;
                CMD_RETRACT: n_retract++;
                default:     n_drop++;
            endcase
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    t_in         in_item   = '0;
    logic        full;
    logic        empty;
    logic        pop       = 1'b0;
    t_out        out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    reject_predictor pred;
    int  n_in          = 0;
    int  n_cfg         = 0;
    int  n_cycles      = 0;
    int  send_idle_pct = 0;
    int  pop_stall_pct = 0;
    bit  hold_req      = 1'b0;

    conveyor_reject_tracker_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .i_in        (in_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Check results before noting inputs: a result never stems from an input of the same edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty) pred.check_result(out_item);
            if (push && !full) begin
                pred.note_item(in_item);
                n_in++;
            end
            if (cfg_valid && cfg_ready) begin
                pred.write_reg(cfg_index, cfg_data);
                n_cfg++;
            end
        end
    end

    // Result side: random stalls, or a long hold-off on request.
    always @(negedge clk) begin
        if (hold_req) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    function automatic t_in mk_verdict(logic signed [31:0] code);
        t_in x;
        x             = '0;
        x.operation   = K_APPEND;
        x.elapsed_ms  = 16'($urandom);
        x.vision_code = code;
        return x;
    endfunction

    function automatic t_in mk_tick(logic [15:0] ms);
        t_in x;
        x             = '0;
        x.operation   = K_TICK;
        x.elapsed_ms  = ms;
        x.vision_code = 32'($urandom);
        return x;
    endfunction

    function automatic t_in mk_good();
        logic signed [31:0] c;
        c = 32'($urandom);
        if (c == CODE_DEFECT) c = 32'sd0;
        return mk_verdict(c);
    endfunction

    function automatic logic [15:0] rand_ms();
        if ($urandom_range(99) < 5) return 16'($urandom);
        return 16'($urandom_range(0, 60));
    endfunction

    // Hold push high across back-to-back transactions; drop it only for idle cycles.
    task automatic offer(input t_in x);
        int c0;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        c0 = n_in;
        push    <= 1'b1;
        in_item <= x;
        do @(negedge clk); while (n_in == c0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        int c0;
        c0 = n_cfg;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (n_cfg == c0);
    endtask

    task automatic configure(input logic [15:0] spd, input logic [31:0] span,
                             input logic [15:0] dly);
        write_reg(REG_LINE_SPEED, {16'($urandom), spd});
        write_reg(REG_PUSH_DISTANCE, span);
        write_reg(REG_RETRACT_DELAY, {16'($urandom), dly});
        write_reg(REG_UNUSED, 32'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Wait out every expected result, then let silent work drain from the block.
    task automatic settle();
        push <= 1'b0;
        while (pred.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_traffic(input int n_items);
        int  done;
        int  roll;
        t_in x;
        done = 0;
        while (done < n_items) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
                repeat ($urandom_range(1, 4)) begin
                    offer(mk_verdict(CODE_DEFECT));
                    done++;
                    if ($urandom_range(3) == 0) offer(mk_good());
                end
                repeat ($urandom_range(1, 6)) begin
                    offer(mk_tick(rand_ms()));
                    done++;
                end
            end else if (roll < 85) begin
                // overfill the store
                repeat ($urandom_range(14, 18)) begin
                    offer(mk_verdict(CODE_DEFECT));
                    done++;
                end
            end else begin
                x             = '0;
                x.operation   = 1'($urandom);
                x.elapsed_ms  = 16'($urandom);
                x.vision_code = 32'($urandom);
                offer(x);
                done++;
            end
        end
    endtask

    int idle_tab  [4] = '{0, 82, 0, 12};
    int stall_tab [4] = '{0, 0, 82, 12};

    initial begin
        int          ph;
        logic [15:0] spd;
        pred = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: belt stopped, nothing moves
        offer(mk_verdict(CODE_DEFECT));
        offer(mk_tick(16'd100));
        settle();

        configure(16'd30000, 32'd1500000, 16'd0);
        offer(mk_verdict(32'sd0));
        offer(mk_verdict(32'sh8000_0000));
        offer(mk_verdict(32'sh7FFF_FFFF));
        offer(mk_verdict(-32'sd1));
        offer(mk_verdict(CODE_DEFECT));
        offer(mk_tick(16'd0));
        offer(mk_tick(16'd50));      // part lands exactly on the push distance
        offer(mk_tick(16'd0));       // zero delay retracts on the next tick
        repeat (3) offer(mk_verdict(CODE_DEFECT));
        offer(mk_tick(16'hFFFF));    // several extends, one retract pending
        offer(mk_tick(16'd0));
        settle();

        configure(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        offer(mk_verdict(CODE_DEFECT));
        offer(mk_tick(16'hFFFF));
        offer(mk_tick(16'hFFFF));    // position saturates
        offer(mk_tick(16'hFFFE));
        offer(mk_tick(16'd1));
        settle();

        configure(16'd0, 32'd0, 16'd500);
        offer(mk_verdict(CODE_DEFECT));
        offer(mk_tick(16'd0));
        settle();

        for (ph = 0; ph < 4; ph++) begin
            spd = 16'($urandom_range(1, 3000));
            configure(spd, 32'(spd) * 32'($urandom_range(20, 150)),
                      16'($urandom_range(0, 120)));
            send_idle_pct = idle_tab[ph];
            pop_stall_pct = stall_tab[ph];
            run_traffic(45);
            settle();
            if (ph == 0) begin
                // back up the result side until the input stalls
                hold_req = 1'b1;
                repeat (20) begin
                    offer(mk_verdict(CODE_DEFECT));
                    offer(mk_tick(16'hFFFF));
                end
                settle();
            end
        end

        repeat (50) @(negedge clk);
        $display("Run covered %0d input transactions under four idle/stall mixes %s",
                 n_in, "and a long hold-off.");
        $display("Checked %0d results: %0d extend, %0d retract, %0d dropped.",
                 pred.n_checked, pred.n_extend, pred.n_retract, pred.n_drop);
        if (pred.n_errors == 0 && pred.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
design/crt_pkg.sv
design/crt_ram.sv
design/crt_fifo.sv
design/crt_front.sv
design/crt_back.sv
design/conveyor_reject_tracker_unit.sv
bench/tb.sv
